// ----- hw/rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Default sizing of the managed region.
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int MAX_ORDER_DEF  = 10;

  // Port field widths.
  localparam int REQ_W    = 11;
  localparam int IDX_W    = 10;
  localparam int ORD_W    = 4;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 11;

  // Reset value of the region size register.
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1024);

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_WALK_RD,
    S_WALK_CHK,
    S_SPLIT,
    S_A_FIN,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_F_FIN
  } bba_state_t;

  // Position of the highest set bit, zero for a zero input.
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // Smallest order whose block count covers the request.
  function automatic logic [4:0] req_order(input logic [REQ_W-1:0] req);
    logic [4:0] r;
    if (req <= REQ_W'(1)) begin
      r = 5'd0;
    end else begin
      r = msb_pos(32'(req - REQ_W'(1))) + 5'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/buddy_block_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | start, busy            | in_func, in_request_blocks, in_block_index
// result   | out_valid (one cycle)  | out_status, out_granted_index, out_granted_order
// config   | cfg_wr_en              | cfg_total_blocks
//
// An allocate is busy while it reads and checks each block head in turn (one memory
// read port), for each split, for the final write and for the end-of-walk check when
// no exact fit turns up; a bad size or a free outside the region is never busy. A
// free reads and checks its head, then each buddy, merging while it can, and ends
// with a final write; a free of a block that is not taken ends after its check. The
// result strobe is registered and comes in the cycle after the last busy cycle (or
// the accepting edge). After reset and after each cfg write a clearing pass over
// every store entry rebuilds the region; busy stays high meanwhile. The receiver
// cannot stall; out_valid marks each result for exactly one cycle.

module buddy_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_ORDER  = bba_pkg::MAX_ORDER_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [bba_pkg::REQ_W-1:0]     in_request_blocks,
  input  wire logic [bba_pkg::IDX_W-1:0]     in_block_index,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bba_pkg::TOTAL_W-1:0]   cfg_total_blocks,
  output logic                               out_valid,
  output logic [bba_pkg::STATUS_W-1:0]       out_status,
  output logic [bba_pkg::IDX_W-1:0]          out_granted_index,
  output logic [bba_pkg::ORD_W-1:0]          out_granted_order
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int LW = AW + 1;
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int MW = OW + 1;

  bba_pkg::bba_state_t state_r, state_nxt;

  logic [MW-1:0] mem [NUM_BLOCKS];
  logic [MW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [AW-1:0] clr_addr_r;
  logic [LW-1:0] head_r;
  logic [LW-1:0] region_len_r;
  logic [LW-1:0] pos_r;
  logic [AW-1:0] best_r;
  logic [OW-1:0] best_o_r;
  logic          found_r;
  logic [OW-1:0] want_r;
  logic [AW-1:0] cur_r;
  logic [OW-1:0] co_r;
  logic [AW-1:0] bud_r;

  logic                         out_valid_r;
  logic [bba_pkg::STATUS_W-1:0] out_status_r;
  logic [bba_pkg::IDX_W-1:0]    out_index_r;
  logic [bba_pkg::ORD_W-1:0]    out_order_r;

  // Decoded fields of the entry read last cycle.
  logic          rd_taken;
  logic [OW-1:0] rd_order;
  assign rd_taken = rdata_r[MW-1];
  assign rd_order = rdata_r[OW-1:0];

  // Request decode.
  logic [4:0] req_ord;
  logic       req_bad;
  logic       idx_out;
  logic       accept;
  assign req_ord = bba_pkg::req_order(in_request_blocks);
  assign req_bad = (in_request_blocks == '0) || (32'(req_ord) > MAX_ORDER);
  assign idx_out = 32'(in_block_index) >= 32'(region_len_r);
  assign accept  = start && !busy;

  // Region rebuild: size of the next head from the remaining block count.
  logic [LW-1:0] clr_rem;
  logic [4:0]    clr_msb;
  logic [OW-1:0] clr_k;
  logic          clr_head;
  logic          clr_last;
  assign clr_rem  = region_len_r - head_r;
  assign clr_msb  = bba_pkg::msb_pos(32'(clr_rem));
  assign clr_k    = (32'(clr_msb) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(clr_msb);
  assign clr_head = (LW'(clr_addr_r) == head_r) && (clr_rem != '0);
  assign clr_last = (32'(clr_addr_r) == NUM_BLOCKS - 1);

  // Walk and buddy helpers.
  logic          pos_end;
  logic [OW-1:0] split_o;
  logic [AW-1:0] merge_bud;
  logic          merge_stop;
  logic          merge_ok;
  assign pos_end    = pos_r >= region_len_r;
  assign split_o    = OW'(best_o_r - OW'(1));
  assign merge_bud  = cur_r ^ (AW'(1) << co_r);
  assign merge_stop = (32'(co_r) >= MAX_ORDER) || (LW'(merge_bud) >= region_len_r);
  assign merge_ok   = !rd_taken && (rd_order == co_r);

  // Clamp of a new region size to the store depth.
  function automatic logic [LW-1:0] clamp_len(input logic [bba_pkg::TOTAL_W-1:0] v);
    logic [LW-1:0] r;
    if (32'(v) > NUM_BLOCKS) r = LW'(NUM_BLOCKS);
    else                     r = LW'(v);
    return r;
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::S_IDLE: begin
        if (accept) begin
          if (in_func == bba_pkg::FUNC_ALLOC) begin
            if (!req_bad) state_nxt = bba_pkg::S_WALK_RD;
          end else if (!idx_out) begin
            state_nxt = bba_pkg::S_FREE_RD;
          end
        end
      end
      bba_pkg::S_CLR: begin
        if (clr_last) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_WALK_RD: begin
        if (pos_end) begin
          if (!found_r)                 state_nxt = bba_pkg::S_IDLE;
          else if (best_o_r > want_r)   state_nxt = bba_pkg::S_SPLIT;
          else                          state_nxt = bba_pkg::S_A_FIN;
        end else begin
          state_nxt = bba_pkg::S_WALK_CHK;
        end
      end
      bba_pkg::S_WALK_CHK: begin
        if (!rd_taken && rd_order == want_r) state_nxt = bba_pkg::S_A_FIN;
        else                                 state_nxt = bba_pkg::S_WALK_RD;
      end
      bba_pkg::S_SPLIT: begin
        if (split_o == want_r) state_nxt = bba_pkg::S_A_FIN;
      end
      bba_pkg::S_A_FIN:    state_nxt = bba_pkg::S_IDLE;
      bba_pkg::S_FREE_RD:  state_nxt = bba_pkg::S_FREE_CHK;
      bba_pkg::S_FREE_CHK: begin
        if (rd_taken) state_nxt = bba_pkg::S_MERGE_RD;
        else          state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_MERGE_RD: begin
        if (merge_stop) state_nxt = bba_pkg::S_F_FIN;
        else            state_nxt = bba_pkg::S_MERGE_CHK;
      end
      bba_pkg::S_MERGE_CHK: begin
        if (merge_ok) state_nxt = bba_pkg::S_MERGE_RD;
        else          state_nxt = bba_pkg::S_F_FIN;
      end
      bba_pkg::S_F_FIN:    state_nxt = bba_pkg::S_IDLE;
      default:             state_nxt = bba_pkg::S_IDLE;
    endcase
    if (cfg_wr_en) state_nxt = bba_pkg::S_CLR;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state_r)
      bba_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = clr_head ? {1'b0, clr_k} : '0;
      end
      bba_pkg::S_WALK_RD:  mem_raddr = pos_r[AW-1:0];
      bba_pkg::S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = best_r ^ (AW'(1) << split_o);
        mem_wdata = {1'b0, split_o};
      end
      bba_pkg::S_A_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = best_r;
        mem_wdata = {1'b1, want_r};
      end
      bba_pkg::S_FREE_RD:  mem_raddr = cur_r;
      bba_pkg::S_MERGE_RD: mem_raddr = merge_bud;
      bba_pkg::S_MERGE_CHK: begin
        // The half that stops being the head takes the merged order now.
        mem_we    = merge_ok;
        mem_waddr = (bud_r > cur_r) ? bud_r : cur_r;
        mem_wdata = {1'b0, OW'(co_r + OW'(1))};
      end
      bba_pkg::S_F_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = {1'b0, co_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Block order and taken store.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bba_pkg::S_CLR;
    else        state_r <= state_nxt;
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      clr_addr_r   <= '0;
      head_r       <= '0;
      region_len_r <= clamp_len(bba_pkg::TOTAL_RESET);
      found_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        bba_pkg::S_IDLE: begin
          if (accept) begin
            pos_r   <= '0;
            found_r <= 1'b0;
            want_r  <= OW'(req_ord);
            cur_r   <= AW'(in_block_index);
            if (in_func == bba_pkg::FUNC_ALLOC && req_bad) begin
              out_valid_r  <= 1'b1;
              out_status_r <= bba_pkg::ST_BADSIZE;
              out_index_r  <= '0;
              out_order_r  <= '0;
            end else if (in_func == bba_pkg::FUNC_FREE && idx_out) begin
              out_valid_r  <= 1'b1;
              out_status_r <= bba_pkg::ST_NOFIT;
              out_index_r  <= '0;
              out_order_r  <= '0;
            end
          end
        end
        bba_pkg::S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_head) head_r <= head_r + (LW'(1) << clr_k);
        end
        bba_pkg::S_WALK_RD: begin
          if (pos_end && !found_r) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bba_pkg::ST_NOFIT;
            out_index_r  <= '0;
            out_order_r  <= '0;
          end
        end
        bba_pkg::S_WALK_CHK: begin
          if (!rd_taken && rd_order == want_r) begin
            best_r   <= pos_r[AW-1:0];
            best_o_r <= rd_order;
            found_r  <= 1'b1;
          end else if (!rd_taken && rd_order > want_r && (!found_r || rd_order < best_o_r)) begin
            best_r   <= pos_r[AW-1:0];
            best_o_r <= rd_order;
            found_r  <= 1'b1;
          end
          pos_r <= pos_r + (LW'(1) << rd_order);
        end
        bba_pkg::S_SPLIT: best_o_r <= split_o;
        bba_pkg::S_A_FIN: begin
          out_valid_r  <= 1'b1;
          out_status_r <= bba_pkg::ST_OK;
          out_index_r  <= bba_pkg::IDX_W'(best_r);
          out_order_r  <= bba_pkg::ORD_W'(want_r);
        end
        bba_pkg::S_FREE_CHK: begin
          co_r <= rd_order;
          if (!rd_taken) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bba_pkg::ST_NOFIT;
            out_index_r  <= '0;
            out_order_r  <= '0;
          end
        end
        bba_pkg::S_MERGE_RD: bud_r <= merge_bud;
        bba_pkg::S_MERGE_CHK: begin
          if (merge_ok) begin
            co_r <= OW'(co_r + OW'(1));
            if (bud_r < cur_r) cur_r <= bud_r;
          end
        end
        bba_pkg::S_F_FIN: begin
          out_valid_r  <= 1'b1;
          out_status_r <= bba_pkg::ST_OK;
          out_index_r  <= '0;
          out_order_r  <= bba_pkg::ORD_W'(co_r);
        end
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
      // A new region size restarts the rebuild.
      if (cfg_wr_en) begin
        region_len_r <= clamp_len(cfg_total_blocks);
        clr_addr_r   <= '0;
        head_r       <= '0;
      end
    end
  end

  assign busy              = (state_r != bba_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_index_r;
  assign out_granted_order = out_order_r;

  // Splitting only happens while the block is still too large.
  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_SPLIT) |-> (best_o_r > want_r))
    else $error("split entered with block already at wanted order");

  // A failed transaction reports neither index nor order.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bba_pkg::ST_OK) |->
    (out_index_r == '0 && out_order_r == '0))
    else $error("failed transaction carries nonzero fields");

  // An accepted transaction either answers at once or keeps the sequencer busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_wr_en) |=> (out_valid_r || state_r != bba_pkg::S_IDLE))
    else $error("accepted transaction dropped");

  // No result is shown during the rebuild pass.
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_CLR) |-> !out_valid_r)
    else $error("result strobe during region rebuild");

endmodule

`default_nettype wire

// ----- sim/bba_checker.sv -----
`timescale 1ns / 1ps

// Watches the command, result and configuration ports of the allocator.
// It keeps its own copy of the block table, predicts each result and
// compares what the block returns against that prediction.
module bba_checker
  import bba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic                in_func,
  input  wire logic [REQ_W-1:0]    in_request_blocks,
  input  wire logic [IDX_W-1:0]    in_block_index,
  input  wire logic                cfg_wr_en,
  input  wire logic [TOTAL_W-1:0]  cfg_total_blocks,
  input  wire logic                out_valid,
  input  wire logic [STATUS_W-1:0] out_status,
  input  wire logic [IDX_W-1:0]    out_granted_index,
  input  wire logic [ORD_W-1:0]    out_granted_order,
  output int                       fail_count,
  output int                       pending_count,
  output int                       result_count
);

  localparam int NBLK = NUM_BLOCKS_DEF;
  localparam int MORD = MAX_ORDER_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    gidx;
    logic [ORD_W-1:0]    gord;
  } grant_t;

  logic [ORD_W-1:0] head_order [NBLK];
  bit               head_taken [NBLK];
  int               region_size;
  grant_t           expected_grants [$];

  // Cut the region into aligned free blocks, largest first.
  function automatic void rebuild_region(input logic [TOTAL_W-1:0] total);
    int n;
    int pos;
    n = (int'(total) > NBLK) ? NBLK : int'(total);
    pos = 0;
    for (int i = 0; i < NBLK; i++) begin
      head_order[i] = '0;
      head_taken[i] = 1'b0;
    end
    region_size = n;
    for (int k = MORD; k >= 0; k--) begin
      while (n - pos >= (1 << k)) begin
        head_order[pos] = ORD_W'(k);
        pos += (1 << k);
      end
    end
  endfunction

  // Apply one transaction to the table and return the grant it produces.
  function automatic grant_t apply_request(input logic f, input logic [REQ_W-1:0] req,
                                           input logic [IDX_W-1:0] idx);
    grant_t g;
    int want;
    int pos;
    int best;
    int o;
    int cur;
    int bud;
    bit found;
    g = '0;
    if (f == FUNC_ALLOC) begin
      want = 0;
      while (want < 31 && (1 << want) < int'(req)) want++;
      if (req == 0 || want > MORD) begin
        g.status = ST_BADSIZE;
      end else begin
        pos = 0;
        best = 0;
        found = 1'b0;
        // First exact fit wins; otherwise the first of the smallest larger order.
        while (pos < region_size) begin
          o = int'(head_order[pos]);
          if (!head_taken[pos]) begin
            if (o == want) begin
              best = pos;
              found = 1'b1;
              break;
            end
            if (o > want && (!found || o < int'(head_order[best]))) begin
              best = pos;
              found = 1'b1;
            end
          end
          pos += (1 << o);
        end
        if (!found) begin
          g.status = ST_NOFIT;
        end else begin
          while (int'(head_order[best]) > want) begin
            o = int'(head_order[best]) - 1;
            bud = best ^ (1 << o);
            head_order[best] = ORD_W'(o);
            if (bud < NBLK) head_order[bud] = ORD_W'(o);
          end
          head_taken[best] = 1'b1;
          g.status = ST_OK;
          g.gidx = IDX_W'(best);
          g.gord = ORD_W'(want);
        end
      end
    end else begin
      if (int'(idx) >= region_size || !head_taken[idx]) begin
        g.status = ST_NOFIT;
      end else begin
        cur = int'(idx);
        head_taken[cur] = 1'b0;
        // Merge upward while the buddy is inside the region, free and the same size.
        while (int'(head_order[cur]) < MORD) begin
          o = int'(head_order[cur]);
          bud = cur ^ (1 << o);
          if (bud >= region_size || head_taken[bud] || int'(head_order[bud]) != o) break;
          head_order[bud] = ORD_W'(o + 1);
          head_order[cur] = ORD_W'(o + 1);
          if (bud < cur) cur = bud;
        end
        g.status = ST_OK;
        g.gord = head_order[cur];
      end
    end
    return g;
  endfunction

  assign pending_count = expected_grants.size();

  // Results are checked before a new transaction is predicted at the same edge.
  always @(posedge clk) begin
    grant_t want_g;
    if (!rst_n) begin
      rebuild_region(TOTAL_RESET);
      expected_grants.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result status=%0d index=%0d order=%0d", $time,
                   out_status, out_granted_index, out_granted_order);
          fail_count <= fail_count + 1;
        end else begin
          want_g = expected_grants.pop_front();
          if (out_status !== want_g.status || out_granted_index !== want_g.gidx ||
              out_granted_order !== want_g.gord) begin
            $display("%0t: mismatch expected status=%0d index=%0d order=%0d, got %0d %0d %0d",
                     $time, want_g.status, want_g.gidx, want_g.gord,
                     out_status, out_granted_index, out_granted_order);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_wr_en) rebuild_region(cfg_total_blocks);
      if (start && !busy)
        expected_grants.push_back(apply_request(in_func, in_request_blocks, in_block_index));
    end
  end

endmodule

// ----- sim/tb_buddy_block_allocator.sv -----
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_func;
  logic [REQ_W-1:0]    in_request_blocks;
  logic [IDX_W-1:0]    in_block_index;
  logic                cfg_wr_en;
  logic [TOTAL_W-1:0]  cfg_total_blocks;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]    out_granted_index;
  logic [ORD_W-1:0]    out_granted_order;
  int                  fail_count;
  int                  pending_count;
  int                  result_count;

  // Heads handed out by the block, used to build well-formed frees.
  logic [IDX_W-1:0]    live_heads [$];
  logic                issued_funcs [$];
  bit                  idle_on;
  int                  accepted_count;

  buddy_block_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_request_blocks(in_request_blocks),
    .in_block_index(in_block_index),
    .cfg_wr_en(cfg_wr_en), .cfg_total_blocks(cfg_total_blocks),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_index(out_granted_index), .out_granted_order(out_granted_order)
  );

  bba_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_request_blocks(in_request_blocks),
    .in_block_index(in_block_index),
    .cfg_wr_en(cfg_wr_en), .cfg_total_blocks(cfg_total_blocks),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_index(out_granted_index), .out_granted_order(out_granted_order),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Track successful allocations so that later frees can target real heads.
  always @(posedge clk) begin
    logic f;
    if (rst_n) begin
      if (out_valid && issued_funcs.size() != 0) begin
        f = issued_funcs.pop_front();
        if (f == FUNC_ALLOC && out_status == ST_OK) live_heads.push_back(out_granted_index);
      end
      if (start && !busy) issued_funcs.push_back(in_func);
    end
  end

  // Present one transaction and hold it until the block takes it.
  task automatic send_request(input logic f, input logic [REQ_W-1:0] req,
                              input logic [IDX_W-1:0] idx);
    start <= 1'b1;
    in_func <= f;
    in_request_blocks <= req;
    in_block_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    accepted_count++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Let every outstanding result arrive, then allow for trailing work.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Resize the region while idle; all allocations are dropped.
  task automatic set_region(input logic [TOTAL_W-1:0] total);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_total_blocks <= total;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    repeat (2) @(posedge clk);
    live_heads.delete();
  endtask

  // Mostly small allocations, with frees of real heads and some noise.
  task automatic random_phase(input int count);
    logic [REQ_W-1:0] req;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (live_heads.size() != 0 &&
          $urandom_range(0, 99) < (live_heads.size() > 40 ? 75 : 40)) begin
        pick = $urandom_range(0, live_heads.size() - 1);
        send_request(FUNC_FREE, '0, live_heads[pick]);
        live_heads.delete(pick);
      end else if ($urandom_range(0, 9) == 0) begin
        send_request(FUNC_FREE, REQ_W'($urandom), IDX_W'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0:       req = REQ_W'($urandom_range(1025, 2047));
          1:       req = '0;
          2, 3:    req = REQ_W'($urandom_range(1, 1024));
          default: req = REQ_W'($urandom_range(1, 16));
        endcase
        send_request(FUNC_ALLOC, req, IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_ALLOC;
    in_request_blocks = '0;
    in_block_index = '0;
    cfg_wr_en = 1'b0;
    cfg_total_blocks = '0;
    idle_on = 1'b1;
    accepted_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full region: size limits, whole-region grab, splits, merges and stray frees.
    set_region(11'd1024);
    send_request(FUNC_ALLOC, 11'd0, '0);
    send_request(FUNC_ALLOC, 11'd2047, '0);
    send_request(FUNC_ALLOC, 11'd1025, '0);
    send_request(FUNC_ALLOC, 11'd1024, '0);
    send_request(FUNC_ALLOC, 11'd1, '0);
    send_request(FUNC_FREE, '0, 10'd0);
    send_request(FUNC_FREE, '0, 10'd0);
    send_request(FUNC_ALLOC, 11'd1, '0);
    send_request(FUNC_ALLOC, 11'd3, '0);
    send_request(FUNC_ALLOC, 11'd2, '0);
    send_request(FUNC_FREE, '0, 10'd1);
    send_request(FUNC_FREE, '0, 10'd4);
    send_request(FUNC_FREE, '0, 10'd0);
    send_request(FUNC_FREE, '0, 10'd2);
    send_request(FUNC_FREE, '0, 10'd1023);

    // Empty region: nothing can be granted or freed.
    set_region(11'd0);
    send_request(FUNC_ALLOC, 11'd1, '0);
    send_request(FUNC_FREE, '0, 10'd0);

    // Odd region: buddies past the end, frees outside the region.
    set_region(11'd37);
    send_request(FUNC_FREE, '0, 10'd1023);
    send_request(FUNC_ALLOC, 11'd32, '0);
    send_request(FUNC_ALLOC, 11'd4, '0);
    send_request(FUNC_ALLOC, 11'd1, '0);
    send_request(FUNC_ALLOC, 11'd1, '0);
    send_request(FUNC_FREE, '0, 10'd36);
    send_request(FUNC_FREE, '0, 10'd32);

    set_region(11'd37);
    random_phase(270);
    set_region(11'd1);
    random_phase(150);
    set_region(11'd2047);
    random_phase(300);
    set_region(11'd1000);
    random_phase(300);
    set_region(TOTAL_W'($urandom_range(2, 1024)));
    random_phase(300);
    set_region(TOTAL_W'($urandom_range(2, 200)));
    random_phase(300);
    // Back-to-back traffic to close the run.
    set_region(11'd1024);
    idle_on = 1'b0;
    random_phase(300);
    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions and %0d results over region sizes 0 to 2047,",
             accepted_count, result_count);
    $display("including bad sizes, full-region grants, split and merge chains.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #250ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- buddy_block_allocator.f -----
hw/rtl/bba_pkg.sv
hw/rtl/buddy_block_allocator.sv
sim/bba_checker.sv
sim/tb_buddy_block_allocator.sv
